[hdl/mqs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mqs_pkg;

   localparam int JOBS_PER_LEVEL_DEF = 16;
   localparam int WORK_BITS_DEF      = 16;
   localparam int LEVELS             = 3;
   localparam int TIME_W             = 22;
   localparam int SLOT_OUT_W         = 4;
   localparam int LEVEL_W            = 2;
   localparam int PRIO_W             = 4;
   localparam int BURST_W            = 16;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [7:0] RR_QUANTUM_RESET  = 8'd4;
   localparam logic [7:0] LEVEL_SLICE_RESET = 8'd10;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [LEVEL_W-1:0] LVL_RR   = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_PRIO = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_FCFS = 2'd2;

   localparam logic REG_RR_QUANTUM  = 1'b0;
   localparam logic REG_LEVEL_SLICE = 1'b1;

   // one above any real priority number
   localparam logic [PRIO_W:0] PRIO_NONE = 5'd16;

   typedef struct packed {
      logic                kind;
      logic [PRIO_W-1:0]   job_priority;
      logic [BURST_W-1:0]  burst;
   } req_data_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]    level;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  rejected;
      logic                  ran;
      logic                  finished;
      logic [TIME_W-1:0]     finish_time;
      logic [TIME_W-1:0]     wait_time;
      logic                  all_done;
   } rsp_data_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic prio_mode;
   } pick_ctrl_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_READ = 5'b00100,
      ST_EXEC = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   function automatic logic [LEVEL_W-1:0] level_of(input logic [PRIO_W-1:0] p);
      logic [LEVEL_W-1:0] l;
      if (p inside {[4'd1:4'd3]}) begin
         l = LVL_RR;
      end else if (p inside {[4'd4:4'd6]}) begin
         l = LVL_PRIO;
      end else begin
         l = LVL_FCFS;
      end
      return l;
   endfunction

endpackage

`default_nettype wire

[hdl/mqs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/mqs_pick.sv]
`timescale 1ns / 1ps
`default_nettype none

module mqs_pick #(
   parameter int SW = 4,
   parameter int WB = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mqs_pkg::pick_ctrl_type        ctrl,
   input  wire logic [SW-1:0]                 in_slot,
   input  wire logic [WB-1:0]                 in_rem,
   input  wire logic [mqs_pkg::PRIO_W-1:0]    in_prio,
   output logic      [SW-1:0]                 best_slot
);

   logic [SW-1:0]              best_slot_ff, best_slot_in;
   logic [mqs_pkg::PRIO_W:0]   best_prio_ff, best_prio_in;
   logic                       found_ff, found_in;
   logic                       take;

   // one compare per streamed entry
   always_comb begin
      take = 1'b0;
      if (ctrl.valid && in_rem != '0) begin
         if (ctrl.prio_mode) begin
            take = {1'b0, in_prio} < best_prio_ff;
         end else begin
            take = !found_ff;
         end
      end
      best_slot_in = best_slot_ff;
      best_prio_in = best_prio_ff;
      found_in     = found_ff;
      if (ctrl.clear) begin
         best_slot_in = '0;
         best_prio_in = mqs_pkg::PRIO_NONE;
         found_in     = 1'b0;
      end else if (take) begin
         best_slot_in = in_slot;
         best_prio_in = {1'b0, in_prio};
         found_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         best_prio_ff <= mqs_pkg::PRIO_NONE;
      end else begin
         found_ff     <= found_in;
         best_prio_ff <= best_prio_in;
      end
      best_slot_ff <= best_slot_in;
   end

   assign best_slot = best_slot_ff;

endmodule

`default_nettype wire

[hdl/multilevel_queue_scheduler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// three-level job scheduler: round robin, priority and first come levels
// req channel: kind 0 adds a job (priority picks the level), kind 1 is one tick
// rsp channel: one result per request, held in an output register
// csr port: rr_quantum at 0x0, level_slice at 0x4, pready always high
// an add goes from accept through ST_OUT into the output register
// a tick whose level already holds a job does read, update and output in turn
// a tick that must pick a job first scans the level's n entries through one compare
// unit fed by the job memory read port, then does the read, update and output
// req_stall is high while a request is being worked on
// when rsp_stall holds the output register, the next request is still taken;
// its result waits in the sequencer until the output register frees
// reset clears counts, cursors, time and the handshakes; job memory is not
// cleared, only entries below each level's count are ever read
module multilevel_queue_scheduler_unit #(
   parameter int JOBS_PER_LEVEL = mqs_pkg::JOBS_PER_LEVEL_DEF,
   parameter int WORK_BITS      = mqs_pkg::WORK_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire mqs_pkg::req_data_type             req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output mqs_pkg::rsp_data_type                  rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mqs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [mqs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [mqs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int LEVELS = mqs_pkg::LEVELS;
   localparam int DEPTH  = LEVELS * JOBS_PER_LEVEL;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = (JOBS_PER_LEVEL > 1) ? $clog2(JOBS_PER_LEVEL) : 1;
   localparam int CW     = $clog2(JOBS_PER_LEVEL + 1);
   localparam int EW     = 2 * WORK_BITS + mqs_pkg::PRIO_W;
   localparam int TW     = mqs_pkg::TIME_W;
   localparam int LW     = mqs_pkg::LEVEL_W;

   mqs_pkg::state_type     state_ff, state_in;
   logic [7:0]             rrq_ff, rrq_in;
   logic [7:0]             lslice_ff, lslice_in;
   logic [CW-1:0]          count_ff  [LEVELS];
   logic [CW-1:0]          count_in  [LEVELS];
   logic [CW-1:0]          pend_ff   [LEVELS];
   logic [CW-1:0]          pend_in   [LEVELS];
   logic [SW-1:0]          cursor_ff [LEVELS];
   logic [SW-1:0]          cursor_in [LEVELS];
   logic [LEVELS-1:0]      held_ff, held_in;
   logic [7:0]             quantum_ff, quantum_in;
   logic [7:0]             slice_ff, slice_in;
   logic [LW-1:0]          cur_lvl_ff, cur_lvl_in;
   logic [LW-1:0]          job_lvl_ff, job_lvl_in;
   logic [TW-1:0]          busy_ff, busy_in;
   logic [SW-1:0]          scan_start_ff, scan_start_in;
   logic [CW-1:0]          scan_k_ff, scan_k_in;
   logic                   eval_valid_ff, eval_valid_in;
   logic [SW-1:0]          eval_slot_ff, eval_slot_in;
   mqs_pkg::rsp_data_type  res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mqs_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;

   logic                   req_accept, csr_write;
   logic [LEVELS-1:0]      pend_nz;
   logic [LW-1:0]          add_lvl, nxt_lvl, c1, c2, tick_lvl, sel_lvl;
   logic                   need_switch;
   logic [7:0]             lim_q, lim_slice;
   logic [CW-1:0]          sel_count, sel_pend;
   logic [SW-1:0]          sel_cursor;
   logic                   sel_held;
   logic [WORK_BITS-1:0]   burst_w;
   logic                   add_reject;
   logic [CW:0]            scan_sum;
   logic [SW-1:0]          scan_slot;
   logic [CW:0]            slot_next;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [EW-1:0]          wr_data, rd_data;
   logic [WORK_BITS-1:0]   rd_rem, rd_burst, rem_dec;
   logic [mqs_pkg::PRIO_W-1:0] rd_prio;
   logic [8:0]             q_next;
   logic [TW-1:0]          busy_next;

   mqs_pkg::pick_ctrl_type pick_ctrl;
   logic [SW-1:0]          best_slot;

   function automatic logic [AW-1:0] entry_addr(input logic [LW-1:0] l,
                                                input logic [SW-1:0] s);
      return AW'(l) * AW'(JOBS_PER_LEVEL) + AW'(s);
   endfunction

   assign req_stall  = (state_ff != mqs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == mqs_pkg::REG_LEVEL_SLICE) ?
                       {24'd0, lslice_ff} : {24'd0, rrq_ff};

   assign lim_q     = (rrq_ff == 8'd0) ? 8'd1 : rrq_ff;
   assign lim_slice = (lslice_ff == 8'd0) ? 8'd1 : lslice_ff;

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         pend_nz[l] = (pend_ff[l] != '0);
      end
   end

   // level turn: next level in cyclic order with pending work
   always_comb begin
      c1 = (cur_lvl_ff == mqs_pkg::LVL_FCFS) ? mqs_pkg::LVL_RR : cur_lvl_ff + 2'd1;
      c2 = (c1 == mqs_pkg::LVL_FCFS) ? mqs_pkg::LVL_RR : c1 + 2'd1;
      if (pend_nz[c1]) begin
         nxt_lvl = c1;
      end else if (pend_nz[c2]) begin
         nxt_lvl = c2;
      end else begin
         nxt_lvl = cur_lvl_ff;
      end
      need_switch = (slice_ff >= lim_slice) || !pend_nz[cur_lvl_ff];
      tick_lvl    = need_switch ? nxt_lvl : cur_lvl_ff;
   end

   assign add_lvl = mqs_pkg::level_of(req_data.job_priority);

   always_comb begin
      if (state_ff == mqs_pkg::ST_IDLE) begin
         sel_lvl = (req_data.kind == mqs_pkg::KIND_ADD) ? add_lvl : tick_lvl;
      end else begin
         sel_lvl = job_lvl_ff;
      end
   end

   assign sel_count  = count_ff[sel_lvl];
   assign sel_pend   = pend_ff[sel_lvl];
   assign sel_cursor = cursor_ff[sel_lvl];
   assign sel_held   = held_ff[sel_lvl];

   assign burst_w    = WORK_BITS'(req_data.burst);
   assign add_reject = (burst_w == '0) || (sel_count >= CW'(JOBS_PER_LEVEL));

   assign scan_sum  = (CW+1)'(scan_start_ff) + (CW+1)'(scan_k_ff);
   assign scan_slot = (scan_sum >= (CW+1)'(sel_count)) ?
                      SW'(scan_sum - (CW+1)'(sel_count)) : SW'(scan_sum);

   assign rd_rem   = rd_data[WORK_BITS-1:0];
   assign rd_burst = rd_data[2*WORK_BITS-1:WORK_BITS];
   assign rd_prio  = rd_data[EW-1:2*WORK_BITS];
   assign rem_dec  = rd_rem - WORK_BITS'(1);
   assign q_next   = {1'b0, quantum_ff} + 9'd1;
   assign busy_next = busy_ff + TW'(1);
   assign slot_next = (CW+1)'(sel_cursor) + (CW+1)'(1);

   always_comb begin
      state_in      = state_ff;
      rrq_in        = rrq_ff;
      lslice_in     = lslice_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      cursor_in     = cursor_ff;
      held_in       = held_ff;
      quantum_in    = quantum_ff;
      slice_in      = slice_ff;
      cur_lvl_in    = cur_lvl_ff;
      job_lvl_in    = job_lvl_ff;
      busy_in       = busy_ff;
      scan_start_in = scan_start_ff;
      scan_k_in     = scan_k_ff;
      eval_valid_in = 1'b0;
      eval_slot_in  = eval_slot_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;
      pick_ctrl     = '0;
      pick_ctrl.prio_mode = (job_lvl_ff == mqs_pkg::LVL_PRIO);
      pick_ctrl.valid     = eval_valid_ff;

      if (csr_write) begin
         if (csr_paddr[2] == mqs_pkg::REG_RR_QUANTUM) begin
            rrq_in = csr_pwdata[7:0];
         end else begin
            lslice_in = csr_pwdata[7:0];
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mqs_pkg::ST_IDLE: begin
            if (req_accept) begin
               res_in = '0;
               state_in = mqs_pkg::ST_OUT;
               if (req_data.kind == mqs_pkg::KIND_ADD) begin
                  res_in.level    = add_lvl;
                  res_in.rejected = add_reject;
                  if (!add_reject) begin
                     res_in.slot       = mqs_pkg::SLOT_OUT_W'(sel_count);
                     wr_en             = 1'b1;
                     wr_addr           = entry_addr(add_lvl, SW'(sel_count));
                     wr_data           = {req_data.job_priority, burst_w, burst_w};
                     count_in[add_lvl] = sel_count + CW'(1);
                     pend_in[add_lvl]  = sel_pend + CW'(1);
                  end
               end else if (pend_nz == '0) begin
                  res_in.level = cur_lvl_ff;
               end else begin
                  if (need_switch) begin
                     cur_lvl_in = nxt_lvl;
                     slice_in   = 8'd0;
                     quantum_in = 8'd0;
                  end
                  job_lvl_in = tick_lvl;
                  if (sel_held) begin
                     state_in = mqs_pkg::ST_READ;
                  end else begin
                     scan_start_in   = (CW'(sel_cursor) >= sel_count) ? '0 : sel_cursor;
                     scan_k_in       = '0;
                     pick_ctrl.clear = 1'b1;
                     state_in        = mqs_pkg::ST_SCAN;
                  end
               end
            end
         end
         mqs_pkg::ST_SCAN: begin
            // issue one entry read a cycle; the compare sees it in the next cycle
            if (scan_k_ff < sel_count) begin
               rd_addr       = entry_addr(job_lvl_ff, scan_slot);
               eval_valid_in = 1'b1;
               eval_slot_in  = scan_slot;
               scan_k_in     = scan_k_ff + CW'(1);
            end else if (!eval_valid_ff) begin
               cursor_in[job_lvl_ff] = best_slot;
               held_in[job_lvl_ff]   = 1'b1;
               state_in              = mqs_pkg::ST_READ;
            end
         end
         mqs_pkg::ST_READ: begin
            rd_addr  = entry_addr(job_lvl_ff, sel_cursor);
            state_in = mqs_pkg::ST_EXEC;
         end
         mqs_pkg::ST_EXEC: begin
            wr_en      = 1'b1;
            wr_addr    = entry_addr(job_lvl_ff, sel_cursor);
            wr_data    = {rd_prio, rd_burst, rem_dec};
            busy_in    = busy_next;
            slice_in   = slice_ff + 8'd1;
            res_in.level = job_lvl_ff;
            res_in.slot  = mqs_pkg::SLOT_OUT_W'(sel_cursor);
            res_in.ran   = 1'b1;
            if (rem_dec == '0) begin
               res_in.finished     = 1'b1;
               res_in.finish_time  = busy_next;
               res_in.wait_time    = busy_next - TW'(rd_burst);
               held_in[job_lvl_ff] = 1'b0;
               quantum_in          = 8'd0;
               pend_in[job_lvl_ff] = sel_pend - CW'(1);
            end else if (job_lvl_ff == mqs_pkg::LVL_RR) begin
               if (q_next >= {1'b0, lim_q}) begin
                  quantum_in = 8'd0;
                  held_in[mqs_pkg::LVL_RR] = 1'b0;
                  cursor_in[mqs_pkg::LVL_RR] =
                     (slot_next >= (CW+1)'(count_ff[mqs_pkg::LVL_RR])) ?
                     '0 : SW'(slot_next);
               end else begin
                  quantum_in = q_next[7:0];
               end
            end
            state_in = mqs_pkg::ST_OUT;
         end
         mqs_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in          = res_ff;
               rsp_data_in.all_done = (pend_nz == '0);
               rsp_valid_in         = 1'b1;
               state_in             = mqs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mqs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mqs_pkg::ST_IDLE;
         rrq_ff        <= mqs_pkg::RR_QUANTUM_RESET;
         lslice_ff     <= mqs_pkg::LEVEL_SLICE_RESET;
         for (int l = 0; l < LEVELS; l++) begin
            count_ff[l]  <= '0;
            pend_ff[l]   <= '0;
            cursor_ff[l] <= '0;
         end
         held_ff       <= '0;
         quantum_ff    <= '0;
         slice_ff      <= '0;
         cur_lvl_ff    <= mqs_pkg::LVL_RR;
         busy_ff       <= '0;
         eval_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rrq_ff        <= rrq_in;
         lslice_ff     <= lslice_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         cursor_ff     <= cursor_in;
         held_ff       <= held_in;
         quantum_ff    <= quantum_in;
         slice_ff      <= slice_in;
         cur_lvl_ff    <= cur_lvl_in;
         busy_ff       <= busy_in;
         eval_valid_ff <= eval_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      job_lvl_ff    <= job_lvl_in;
      scan_start_ff <= scan_start_in;
      scan_k_ff     <= scan_k_in;
      eval_slot_ff  <= eval_slot_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mqs_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mqs_pick #(
      .SW (SW),
      .WB (WORK_BITS)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pick_ctrl),
      .in_slot   (eval_slot_ff),
      .in_rem    (rd_rem),
      .in_prio   (rd_prio),
      .best_slot (best_slot)
   );

   // pending jobs never outnumber stored jobs
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff[0] <= count_ff[0]) && (pend_ff[1] <= count_ff[1]) &&
      (pend_ff[2] <= count_ff[2]))
      else $error("pending count above level count");

   // a scan only runs on a level that has pending work
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqs_pkg::ST_SCAN) |-> pend_nz[job_lvl_ff])
      else $error("scan on level without pending work");

   // the job chosen to run still has work left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqs_pkg::ST_EXEC) |-> (rd_rem != '0))
      else $error("running a job with no work left");

   // a finished tick leaves its level without a held job
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqs_pkg::ST_EXEC && rem_dec == '0) |=> !held_ff[$past(job_lvl_ff)])
      else $error("hold kept after finish");

endmodule

`default_nettype wire
